### src/dmvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmvp_pkg;

   localparam int LEVEL_W   = 14;
   localparam int CFG_W     = 14;
   localparam int FRAC_W    = 9;
   localparam int QUO_BITS  = LEVEL_W;
   localparam int CSR_IDX_W = 2;
   localparam int CMD_W     = LEVEL_W + 1;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
   localparam logic [FRAC_W-1:0]  FRAC_ONE  = 9'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_RISE_STEP      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEVEL      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECEL_FRACTION = 2'd3;

   localparam logic [CFG_W-1:0]  RISE_STEP_RST      = 14'd400;
   localparam logic [CFG_W-1:0]  MIN_LEVEL_RST      = 14'd2000;
   localparam logic [CFG_W-1:0]  RAMP_STEP_RST      = 14'd200;
   localparam logic [FRAC_W-1:0] DECEL_FRACTION_RST = 9'd179;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_RUN,
      PHASE_STOP
   } phase_type;

   typedef enum logic [1:0] {
      DIR_NONE,
      DIR_FWD,
      DIR_BWD
   } dir_type;

   typedef enum logic [1:0] {
      RES_START,
      RES_RUN,
      RES_SHORT
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        start;
      logic        decel;
      logic        sum;
      logic        rem;
      logic        mul;
      logic        div_init;
      logic        div_step;
      logic        commit;
      res_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic      is_tick;
      phase_type phase;
      logic      accel;
      logic      skip_div;
   } dp_status_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] drive_command;
      logic                    tare_request;
      logic                    move_done;
   } result_type;

endpackage

`default_nettype wire

### src/dmvp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dmvp_req_if import dmvp_pkg::*; #(
   parameter int POSITION_BITS = 21
) ();

   logic                            valid;
   logic                            ready;
   logic                            action;
   logic signed [POSITION_BITS-1:0] target_degrees;
   logic        [LEVEL_W-1:0]       peak_level;
   logic signed [POSITION_BITS-1:0] left_position;
   logic signed [POSITION_BITS-1:0] right_position;

   modport source (
      output valid, action, target_degrees, peak_level, left_position, right_position,
      input  ready
   );

   modport sink (
      input  valid, action, target_degrees, peak_level, left_position, right_position,
      output ready
   );

endinterface

`default_nettype wire

### src/dmvp_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dmvp_rsp_if import dmvp_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic signed [CMD_W-1:0] drive_command;
   logic                    tare_request;
   logic                    move_done;

   modport source (
      output valid, drive_command, tare_request, move_done,
      input  ready
   );

   modport sink (
      input  valid, drive_command, tare_request, move_done,
      output ready
   );

endinterface

`default_nettype wire

### src/distance_move_voltage_profile.sv
`timescale 1ns / 1ps
`default_nettype none

// Trapezoidal drive-level profile for a distance move. A start transfer latches the
// target and peak level and is answered by a transfer with tare_request set; each tick
// transfer gives one signed drive level from the averaged encoder positions, and
// move_done marks the end of the move. One item is processed at a time: a start passes
// decode, start and decel states; a tick while idle or in the stop ramp is answered in
// decode; a running tick passes sum, remainder and multiply, and a decelerating tick
// may then run a restoring divider, one quotient bit per cycle. A registered output stage
// lets the next item be accepted while a result is still waiting to be taken.
module distance_move_voltage_profile import dmvp_pkg::*; #(
   parameter int POSITION_BITS = 21,
   parameter int END_TOLERANCE = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   dmvp_req_if.sink                  req_ch,
   dmvp_rsp_if.source                rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   result_type    result;
   result_type    rsp_data_ff;
   logic          rsp_valid_ff;
   logic          out_free;
   logic          req_ready;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   dmvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .out_free  (out_free),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   dmvp_datapath #(
      .POSITION_BITS (POSITION_BITS),
      .END_TOLERANCE (END_TOLERANCE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .action         (req_ch.action),
      .target_degrees (req_ch.target_degrees),
      .peak_level     (req_ch.peak_level),
      .left_position  (req_ch.left_position),
      .right_position (req_ch.right_position),
      .cmd            (cmd),
      .status         (status),
      .result         (result)
   );

   // output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= result;
      end
   end

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.drive_command = rsp_data_ff.drive_command;
   assign rsp_ch.tare_request  = rsp_data_ff.tare_request;
   assign rsp_ch.move_done     = rsp_data_ff.move_done;

endmodule

`default_nettype wire

### src/dmvp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dmvp_datapath import dmvp_pkg::*; #(
   parameter int POSITION_BITS = 21,
   parameter int END_TOLERANCE = 2
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [CSR_IDX_W-1:0]            csr_index,
   input  wire logic [CFG_W-1:0]                csr_wdata,
   input  wire logic                            action,
   input  wire logic signed [POSITION_BITS-1:0] target_degrees,
   input  wire logic [LEVEL_W-1:0]              peak_level,
   input  wire logic signed [POSITION_BITS-1:0] left_position,
   input  wire logic signed [POSITION_BITS-1:0] right_position,
   input  wire dp_cmd_type                      cmd,
   output dp_status_type                        status,
   output result_type                           result
);

   localparam int P      = POSITION_BITS;
   localparam int MAG_W  = P - 1;
   localparam int SUM_W  = P + 1;
   localparam int SUMX_W = P + 2;
   localparam int NUM_W  = P + LEVEL_W;
   localparam int DSH_W  = NUM_W - 1;
   localparam int PROD_W = MAG_W + FRAC_W;
   localparam logic [MAG_W-1:0]  MAG_MAX = '1;
   localparam logic [SUMX_W-1:0] TOL2    = SUMX_W'(2 * END_TOLERANCE);

   // configuration
   logic [CFG_W-1:0]  rise_step_ff;
   logic [CFG_W-1:0]  min_level_ff;
   logic [CFG_W-1:0]  ramp_step_ff;
   logic [FRAC_W-1:0] decel_fraction_ff;

   // captured item
   logic                action_ff;
   logic signed [P-1:0] target_ff;
   logic [LEVEL_W-1:0]  peak_in_ff;
   logic signed [P-1:0] left_ff;
   logic signed [P-1:0] right_ff;

   // move state
   phase_type          phase_ff;
   phase_type          phase_in;
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic [MAG_W-1:0]   mag_ff;
   logic [MAG_W-1:0]   mag_in;
   logic [MAG_W-1:0]   decel_ff;
   logic [MAG_W-1:0]   decel_in;
   logic [LEVEL_W-1:0] peak_ff;
   dir_type            dir_ff;
   dir_type            dir_in;

   // tick work registers
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_in;
   logic [P-1:0]       rem_ff;
   logic [P-1:0]       rem_in;
   logic [P-1:0]       div_ff;
   logic [P-1:0]       div_in;
   logic               accel_path_ff;
   logic               accel_path_in;
   logic               end_ff;
   logic               end_in;
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   num_in;
   logic [NUM_W-1:0]   r_ff;
   logic [DSH_W-1:0]   dsh_ff;
   logic [QUO_BITS-1:0] q_ff;

   logic [P-1:0]        target_abs;
   logic [P-1:0]        left_abs;
   logic [P-1:0]        right_abs;
   logic [FRAC_W-1:0]   frac_use;
   logic [PROD_W-1:0]   decel_prod;
   logic [P-1:0]        two_mag;
   logic [P-1:0]        two_decel;
   logic                div_zero;
   logic                div_ovf;
   logic                div_fits;
   logic [LEVEL_W:0]    acc_sum;
   logic [LEVEL_W-1:0]  acc_lvl;
   logic [LEVEL_W-1:0]  dec_lvl;
   logic [LEVEL_W-1:0]  run_lvl;
   logic [LEVEL_W-1:0]  stop_lvl;
   logic [LEVEL_W-1:0]  ramp_eff;
   logic [LEVEL_W-1:0]  ramp_src;
   logic [LEVEL_W-1:0]  ramp_down;
   logic [LEVEL_W-1:0]  res_lvl;
   logic                res_tare;
   logic                res_done;
   logic signed [CMD_W-1:0] lvl_signed;

   // start decode
   assign target_abs = target_ff[P-1] ? $unsigned(-target_ff) : $unsigned(target_ff);
   assign mag_in     = target_abs[P-1] ? MAG_MAX : target_abs[MAG_W-1:0];
   assign dir_in     = target_ff[P-1] ? DIR_BWD : ((target_ff != '0) ? DIR_FWD : DIR_NONE);
   assign frac_use   = (decel_fraction_ff > FRAC_ONE) ? FRAC_ONE : decel_fraction_ff;
   assign decel_prod = PROD_W'(mag_ff) * PROD_W'(frac_use);
   assign decel_in   = decel_prod[MAG_W+7:8];

   // tick arithmetic
   assign left_abs  = left_ff[P-1] ? $unsigned(-left_ff) : $unsigned(left_ff);
   assign right_abs = right_ff[P-1] ? $unsigned(-right_ff) : $unsigned(right_ff);
   assign sum_in    = {1'b0, left_abs} + {1'b0, right_abs};
   assign two_mag   = {mag_ff, 1'b0};
   assign two_decel = {decel_ff, 1'b0};

   assign rem_in        = ({1'b0, two_mag} > sum_ff) ? (two_mag - sum_ff[P-1:0]) : '0;
   assign accel_path_in = sum_ff < {1'b0, two_decel};
   assign end_in        = (SUMX_W'(sum_ff) + TOL2) >= SUMX_W'(two_mag);
   assign div_in        = {mag_ff - decel_ff, 1'b0};
   assign num_in        = NUM_W'(peak_ff) * NUM_W'(rem_ff);

   assign div_zero = (div_ff == '0);
   assign div_ovf  = num_ff >= {div_ff, {LEVEL_W{1'b0}}};
   assign div_fits = r_ff >= {1'b0, dsh_ff};

   // level selection
   assign acc_sum   = {1'b0, level_ff} + {1'b0, rise_step_ff};
   assign acc_lvl   = (acc_sum > {1'b0, peak_ff}) ? peak_ff : acc_sum[LEVEL_W-1:0];
   assign dec_lvl   = (q_ff < min_level_ff) ? min_level_ff : q_ff;
   assign run_lvl   = accel_path_ff ? acc_lvl : dec_lvl;
   assign stop_lvl  = (run_lvl > min_level_ff) ? run_lvl : min_level_ff;
   assign ramp_eff  = (ramp_step_ff == '0) ? LEVEL_W'(1) : ramp_step_ff;
   assign ramp_src  = (cmd.sel == RES_RUN) ? stop_lvl : level_ff;
   assign ramp_down = (ramp_src > ramp_eff) ? (ramp_src - ramp_eff) : '0;

   always_comb begin
      phase_in = phase_ff;
      level_in = level_ff;
      res_lvl  = '0;
      res_tare = 1'b0;
      res_done = 1'b0;
      case (cmd.sel)
         RES_START: begin
            res_tare = 1'b1;
         end
         RES_RUN: begin
            if (end_ff) begin
               if (stop_lvl == '0) begin
                  level_in = '0;
                  phase_in = PHASE_IDLE;
                  res_done = 1'b1;
               end else begin
                  res_lvl  = stop_lvl;
                  level_in = ramp_down;
                  phase_in = PHASE_STOP;
               end
            end else begin
               res_lvl  = run_lvl;
               level_in = run_lvl;
            end
         end
         RES_SHORT: begin
            if (phase_ff == PHASE_STOP && level_ff != '0) begin
               res_lvl  = level_ff;
               level_in = ramp_down;
            end else begin
               phase_in = PHASE_IDLE;
               res_done = 1'b1;
            end
         end
         default: begin
            res_lvl = '0;
         end
      endcase
      if (cmd.start) begin
         phase_in = PHASE_RUN;
         level_in = '0;
      end
   end

   assign lvl_signed = $signed({1'b0, res_lvl});

   always_comb begin
      result.tare_request = res_tare;
      result.move_done    = res_done;
      case (dir_ff)
         DIR_FWD: result.drive_command = lvl_signed;
         DIR_BWD: result.drive_command = -lvl_signed;
         default: result.drive_command = '0;
      endcase
   end

   assign status.is_tick  = action_ff;
   assign status.phase    = phase_ff;
   assign status.accel    = accel_path_ff;
   assign status.skip_div = div_zero | div_ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_step_ff      <= RISE_STEP_RST;
         min_level_ff      <= MIN_LEVEL_RST;
         ramp_step_ff      <= RAMP_STEP_RST;
         decel_fraction_ff <= DECEL_FRACTION_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RISE_STEP:      rise_step_ff      <= csr_wdata;
            CSR_MIN_LEVEL:      min_level_ff      <= csr_wdata;
            CSR_RAMP_STEP:      ramp_step_ff      <= csr_wdata;
            CSR_DECEL_FRACTION: decel_fraction_ff <= csr_wdata[FRAC_W-1:0];
            default:            rise_step_ff      <= rise_step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         level_ff <= '0;
         mag_ff   <= '0;
         decel_ff <= '0;
         peak_ff  <= '0;
         dir_ff   <= DIR_NONE;
      end else begin
         if (cmd.start || cmd.commit) begin
            phase_ff <= phase_in;
            level_ff <= level_in;
         end
         if (cmd.start) begin
            mag_ff  <= mag_in;
            dir_ff  <= dir_in;
            peak_ff <= peak_in_ff;
         end
         if (cmd.decel) begin
            decel_ff <= decel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= action;
         target_ff  <= target_degrees;
         peak_in_ff <= peak_level;
         left_ff    <= left_position;
         right_ff   <= right_position;
      end
      if (cmd.sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.rem) begin
         rem_ff        <= rem_in;
         div_ff        <= div_in;
         accel_path_ff <= accel_path_in;
         end_ff        <= end_in;
      end
      if (cmd.mul) begin
         num_ff <= num_in;
      end
      if (cmd.div_init) begin
         r_ff   <= num_ff;
         dsh_ff <= {div_ff, {(QUO_BITS-1){1'b0}}};
         q_ff   <= (!div_zero && div_ovf) ? LEVEL_MAX : '0;
      end else if (cmd.div_step) begin
         if (div_fits) begin
            r_ff <= r_ff - {1'b0, dsh_ff};
         end
         dsh_ff <= dsh_ff >> 1;
         q_ff   <= {q_ff[QUO_BITS-2:0], div_fits};
      end
   end

   // remainder stays below twice the current shifted divisor
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> r_ff < {dsh_ff, 1'b0})
      else $error("divider remainder out of range");

   a_start_state: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (phase_ff == PHASE_RUN && level_ff == '0))
      else $error("start did not arm the move");

   a_result_flags: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(result.tare_request && result.move_done))
      else $error("tare and done together");

endmodule

`default_nettype wire

### src/dmvp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dmvp_ctrl import dmvp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          out_free,
   input  wire dp_status_type status,
   output logic               req_ready,
   output dp_cmd_type         cmd
);

   localparam int CNT_W = $clog2(QUO_BITS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_START,
      S_DECEL,
      S_SUM,
      S_REM,
      S_MUL,
      S_OVF,
      S_DIV,
      S_FIN
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;

   always_comb begin
      cmd       = '0;
      cmd.sel   = RES_SHORT;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            if (status.is_tick && status.phase != PHASE_RUN) begin
               cmd.sel    = RES_SHORT;
               cmd.commit = out_free;
            end
         end
         S_START: cmd.start = 1'b1;
         S_DECEL: begin
            cmd.decel  = 1'b1;
            cmd.sel    = RES_START;
            cmd.commit = out_free;
         end
         S_SUM:   cmd.sum      = 1'b1;
         S_REM:   cmd.rem      = 1'b1;
         S_MUL:   cmd.mul      = 1'b1;
         S_OVF:   cmd.div_init = 1'b1;
         S_DIV:   cmd.div_step = 1'b1;
         S_FIN: begin
            cmd.sel    = RES_RUN;
            cmd.commit = out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_DECODE;
            end
            S_DECODE: begin
               if (!status.is_tick) begin
                  state_ff <= S_START;
               end else if (status.phase == PHASE_RUN) begin
                  state_ff <= S_SUM;
               end else if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            S_START: state_ff <= S_DECEL;
            S_DECEL: begin
               if (out_free) state_ff <= S_IDLE;
            end
            S_SUM: state_ff <= S_REM;
            S_REM: state_ff <= S_MUL;
            S_MUL: state_ff <= status.accel ? S_FIN : S_OVF;
            S_OVF: begin
               if (status.skip_div) begin
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_DIV;
                  cnt_ff   <= CNT_W'(QUO_BITS - 1);
               end
            end
            S_DIV: begin
               if (cnt_ff == '0) begin
                  state_ff <= S_FIN;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_FIN: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("result committed into a full output stage");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_DECODE)
      else $error("accepted item not decoded");

   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OVF && !status.skip_div) |=>
         (state_ff == S_DIV && cnt_ff == CNT_W'(QUO_BITS - 1)))
      else $error("divider entered with wrong count");

endmodule

`default_nettype wire
